/* rtl/core/kli_pkg.sv */
package kli_pkg;

  localparam int SLOT_W = 3;
  localparam int TIME_W = 17;
  localparam int VAL_W  = 16;

  // Request kinds carried on s_tuser.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Sequencer states of the track walk.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOOK,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // One key write toward the key store.
  typedef struct packed {
    logic                     en;
    logic [SLOT_W-1:0]        slot;
    logic signed [TIME_W-1:0] key_time;
    logic signed [VAL_W-1:0]  key_value;
  } key_wr_t;

endpackage

/* rtl/core/kli_keymem.sv */
module kli_keymem #(
  parameter int NUM_KEYS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kli_pkg::key_wr_t                  wr,
  input  logic [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] rd_addr,
  output logic signed [kli_pkg::TIME_W-1:0] rd_time,
  output logic signed [kli_pkg::VAL_W-1:0]  rd_value
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic signed [kli_pkg::TIME_W-1:0] times  [NUM_KEYS];
  logic signed [kli_pkg::VAL_W-1:0]  values [NUM_KEYS];
  logic [NUM_KEYS-1:0]               valid;
  logic [AW-1:0]                     wr_addr;
  logic                              wr_hit;

  assign wr_addr = AW'(wr.slot);
  assign wr_hit  = wr.en && (32'(wr.slot) < NUM_KEYS);

  // A slot never written reads as an end marker with a zero value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_hit) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      times[wr_addr]  <= wr.key_time;
      values[wr_addr] <= wr.key_value;
    end
  end

  always_ff @(posedge clk) begin
    if (valid[rd_addr]) begin
      rd_time  <= times[rd_addr];
      rd_value <= values[rd_addr];
    end else begin
      rd_time  <= '1;
      rd_value <= '0;
    end
  end

endmodule

/* rtl/core/kli_div.sv */
module kli_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [2*kli_pkg::TIME_W-1:0] num,
  input  logic [kli_pkg::VAL_W-1:0]         den,
  output logic                              done,
  output logic signed [kli_pkg::VAL_W:0]    quo
);

  localparam int W  = kli_pkg::VAL_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [W-1:0]  rem;
  logic [W-1:0]  low;
  logic [2*kli_pkg::TIME_W-1:0] mag;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // The quotient is known to fit in W bits, so the upper half of the
  // magnitude is already below the divisor and seeds the remainder.
  assign mag     = num[2*kli_pkg::TIME_W-1] ? -num : num;
  assign shifted = {rem, low[W-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[2*kli_pkg::TIME_W-1];
      rem <= mag[2*W-1:W];
      low <= mag[W-1:0];
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        low <= {low[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        low <= {low[W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? -$signed({1'b0, low}) : $signed({1'b0, low});

endmodule

/* rtl/core/keyframe_linear_interpolator.sv */
// Channel | Signals                                  | Request
// input   | s_tvalid s_tready s_tdata[55:0] s_tuser  | key write (tuser 0) or query (tuser 1)
// output  | m_tvalid m_tready m_tdata[15:0]          | track value of one query
//
// A key write never leaves the idle state.
// A query visits the keys with one registered key store read each; a query time
// between two keys then takes a multiply step and the serial divider before hand-off.
// Reset marks every key slot empty; s_tready is low while a query is in work.
// A held result stalls the hand-off of the next query result, and s_tready stays low until then.
module keyframe_linear_interpolator #(
  parameter int NUM_KEYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] key_slot, [19:3] key_time, [35:20] key_value, [52:36] query_time, [55:53] zero
  input  logic [55:0] s_tdata,
  // [0] mode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] track_value
  output logic [15:0] m_tdata
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int TW = kli_pkg::TIME_W;
  localparam int VW = kli_pkg::VAL_W;

  kli_pkg::state_t state, state_next;

  logic                 in_acc;
  logic                 out_free;
  logic                 is_query;
  logic signed [TW-1:0] in_query_time;
  kli_pkg::key_wr_t     wr;

  logic [AW-1:0]        idx;
  logic signed [TW-1:0] q;
  logic [VW-1:0]        pt;
  logic signed [VW-1:0] pv;
  logic [VW-1:0]        dq;
  logic [VW-1:0]        den;
  logic signed [VW:0]   dv;
  logic signed [2*TW-1:0] prod;
  logic signed [VW-1:0] res;

  logic signed [TW-1:0] kt;
  logic signed [VW-1:0] kv;
  logic                 div_start;
  logic                 div_done;
  logic signed [VW:0]   div_quo;

  assign s_tready      = (state == kli_pkg::ST_IDLE);
  assign in_acc        = s_tvalid && s_tready;
  assign is_query      = (s_tuser == kli_pkg::MODE_QUERY);
  assign in_query_time = $signed(s_tdata[52:36]);
  assign out_free      = !m_tvalid || m_tready;

  assign wr.en        = in_acc && !is_query;
  assign wr.slot      = s_tdata[2:0];
  assign wr.key_time  = $signed(s_tdata[19:3]);
  assign wr.key_value = $signed(s_tdata[35:20]);

  kli_keymem #(
    .NUM_KEYS (NUM_KEYS)
  ) u_keymem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (idx),
    .rd_time  (kt),
    .rd_value (kv)
  );

  kli_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The product is registered at the end of the multiply cycle, so the
  // divider start strobe follows in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == kli_pkg::ST_MUL);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kli_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          state_next = in_query_time[TW-1] ? kli_pkg::ST_FIN : kli_pkg::ST_FETCH;
        end
      end
      kli_pkg::ST_FETCH: state_next = kli_pkg::ST_LOOK;
      kli_pkg::ST_LOOK: begin
        priority if (q == kt || kt[TW-1]) begin
          state_next = kli_pkg::ST_FIN;
        end else if (q > kt) begin
          state_next = (idx == AW'(NUM_KEYS - 1)) ? kli_pkg::ST_FIN : kli_pkg::ST_FETCH;
        end else begin
          state_next = kli_pkg::ST_MUL;
        end
      end
      kli_pkg::ST_MUL: state_next = kli_pkg::ST_DIV;
      kli_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = kli_pkg::ST_FIN;
        end
      end
      kli_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = kli_pkg::ST_IDLE;
        end
      end
      default: state_next = kli_pkg::ST_IDLE;
    endcase
  end

  // Walk datapath. The previous key starts out as time 0, value 0.
  always_ff @(posedge clk) begin
    unique case (state)
      kli_pkg::ST_IDLE: begin
        q   <= in_query_time;
        idx <= '0;
        pt  <= '0;
        pv  <= '0;
        res <= '0;
      end
      kli_pkg::ST_LOOK: begin
        priority if (q == kt) begin
          res <= kv;
        end else if (kt[TW-1]) begin
          res <= pv;
        end else if (q > kt) begin
          pt  <= kt[VW-1:0];
          pv  <= kv;
          idx <= idx + 1'b1;
          res <= '0;
        end else begin
          // Here pt <= q < kt, so q - pt is non-negative, kt - pt is positive, and both fit VW bits.
          dq  <= q[VW-1:0] - pt;
          den <= kt[VW-1:0] - pt;
          dv  <= {kv[VW-1], kv} - {pv[VW-1], pv};
        end
      end
      kli_pkg::ST_MUL: begin
        prod <= dv * $signed({1'b0, dq});
      end
      kli_pkg::ST_DIV: begin
        if (div_done) begin
          res <= pv + div_quo[VW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == kli_pkg::ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kli_pkg::ST_FIN && out_free) begin
      m_tdata <= res;
    end
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == kli_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_query) |=> !s_tready)
    else $error("input still ready after a query request");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !is_query) |=> state == kli_pkg::ST_IDLE)
    else $error("key write left the idle state");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == kli_pkg::ST_MUL |-> den != '0)
    else $error("zero interval between keys reached the divider");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == kli_pkg::ST_FIN && out_free) |=> m_tvalid)
    else $error("finished query did not present a result");

endmodule

/* dv/keyframe_track_checker.sv */
module keyframe_track_checker #(
  parameter int NUM_KEYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [2:0] key_slot, [19:3] key_time, [35:20] key_value, [52:36] query_time, [55:53] zero
  input  logic [55:0] s_tdata,
  // [0] mode
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] track_value
  input  logic [15:0] m_tdata,
  output int          errors,
  output int          outstanding,
  output int          results_seen,
  output int          interpolated
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [kli_pkg::TIME_W-1:0] at;
    logic signed [kli_pkg::VAL_W-1:0]  value;
  } track_point_t;

  track_point_t                      track_values_due[$];
  logic signed [kli_pkg::TIME_W-1:0] key_time_mem [NUM_KEYS];
  logic signed [kli_pkg::VAL_W-1:0]  key_value_mem [NUM_KEYS];

  // Walks the keys in slot order and returns the track value at time q.
  function automatic logic signed [kli_pkg::VAL_W-1:0] eval_track(
    input  logic signed [kli_pkg::TIME_W-1:0] q,
    output bit                                interp
  );
    int     t1, v1, t2, v2;
    longint num, den, sum;
    interp = 1'b0;
    if (q < 0) return '0;
    for (int n = 0; n < NUM_KEYS; n++) begin
      if (q == key_time_mem[n]) return key_value_mem[n];
      if (key_time_mem[n] < 0) return (n == 0) ? '0 : key_value_mem[n-1];
      if (q > key_time_mem[n]) continue;
      // Before the first key the segment starts at time 0, value 0.
      t1 = (n == 0) ? 0 : key_time_mem[n-1];
      v1 = (n == 0) ? 0 : key_value_mem[n-1];
      t2 = key_time_mem[n];
      v2 = key_value_mem[n];
      if (t1 == t2) return v2[kli_pkg::VAL_W-1:0];
      interp = 1'b1;
      num = longint'(int'(q) - t1) * longint'(v2 - v1);
      den = t2 - t1;
      sum = v1 + num / den;
      return sum[kli_pkg::VAL_W-1:0];
    end
    return '0;
  endfunction

  always @(posedge clk) begin : monitor
    track_point_t                      due;
    logic signed [kli_pkg::TIME_W-1:0] q;
    bit                                interp;
    if (rst) begin
      for (int n = 0; n < NUM_KEYS; n++) begin
        key_time_mem[n]  = -1;
        key_value_mem[n] = '0;
      end
      track_values_due.delete();
      errors       = 0;
      results_seen = 0;
      interpolated = 0;
    end else begin
      // Results are checked before new requests are queued, so a result in the
      // same cycle as a query can never be matched against that query.
      if (m_tvalid && m_tready) begin
        if (track_values_due.size() == 0) begin
          errors++;
          $display("%0t: track value %0d arrived with no query outstanding (expected none)",
                   $time, $signed(m_tdata));
        end else begin
          due = track_values_due.pop_front();
          results_seen++;
          if (m_tdata !== due.value) begin
            errors++;
            $display("%0t: track value at time %0d: expected %0d, got %0d",
                     $time, due.at, due.value, $signed(m_tdata));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == kli_pkg::MODE_WRITE) begin
          if (int'(s_tdata[2:0]) < NUM_KEYS) begin
            key_time_mem[s_tdata[2:0]]  = s_tdata[19:3];
            key_value_mem[s_tdata[2:0]] = s_tdata[35:20];
          end
        end else if (s_tuser == kli_pkg::MODE_QUERY) begin
          q         = s_tdata[52:36];
          due.at    = q;
          due.value = eval_track(q, interp);
          if (interp) interpolated++;
          track_values_due.push_back(due);
        end
      end
    end
    outstanding = track_values_due.size();
  end

endmodule

/* dv/keyframe_linear_interpolator_tb.sv */
module keyframe_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   STALL_LIMIT = 2000;
  localparam int   NUM_ITEMS   = 1500;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  int errors, outstanding, results_seen, interpolated;
  int n_writes, n_queries;
  int idle_cycles;
  bit calm;
  logic signed [16:0] planned_time [8];

  keyframe_linear_interpolator #(.NUM_KEYS(8)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  keyframe_track_checker #(.NUM_KEYS(8)) track_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .interpolated (interpolated)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("keyframe_linear_interpolator verification failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic mode, input logic [2:0] slot,
                          input logic signed [16:0] kt, input logic signed [15:0] kv,
                          input logic signed [16:0] qt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  <= mode;
    s_tdata  <= {3'b000, qt, kv, kt, slot};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (mode == kli_pkg::MODE_WRITE) n_writes++;
    else n_queries++;
  endtask

  task automatic put_key(input logic [2:0] slot, input logic signed [16:0] kt,
                         input logic signed [15:0] kv);
    planned_time[slot] = kt;
    send_req(kli_pkg::MODE_WRITE, slot, kt, kv, 17'($urandom));
  endtask

  // Key fields of a query are filled with noise; the block must ignore them.
  task automatic ask(input logic signed [16:0] q);
    send_req(kli_pkg::MODE_QUERY, 3'($urandom), 17'($urandom), 16'($urandom), q);
  endtask

  initial begin : result_sink
    int len;
    m_tready = 1'b0;
    forever begin
      len = $urandom_range(10, 150);
      case ($urandom_range(0, 5))
        0, 1: repeat (len) begin
          @(negedge clk);
          m_tready <= 1'b1;
        end
        2: repeat ($urandom_range(20, 60)) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
        default: repeat (len) begin
          @(negedge clk);
          m_tready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  initial begin : stimulus
    int nkeys, step, t, last_t, t_hi, nq, sel;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tuser     = kli_pkg::MODE_WRITE;
    s_tdata     = '0;
    calm        = 1'b1;
    n_writes    = 0;
    n_queries   = 0;
    for (int i = 0; i < 8; i++) planned_time[i] = -1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty track and negative query times.
    ask(17'sd0);
    ask(-17'sd65536);
    // A small track with a double key and an end marker.
    put_key(3'd0, 17'sd100, 16'sd256);
    put_key(3'd1, 17'sd200, -16'sd256);
    put_key(3'd2, 17'sd200, 16'sd512);
    put_key(3'd3, 17'sd1000, 16'sd32767);
    put_key(3'd4, -17'sd1, 16'sd0);
    ask(17'sd50);
    ask(17'sd100);
    ask(17'sd150);
    ask(17'sd200);
    ask(17'sd600);
    ask(17'sd5000);
    ask(-17'sd1);
    // Full track without an end marker, full value swing at the top of time.
    put_key(3'd4, 17'sd65000, -16'sd32768);
    put_key(3'd5, 17'sd65100, 16'sd32767);
    put_key(3'd6, 17'sd65200, 16'sd0);
    put_key(3'd7, 17'sd65535, 16'sd100);
    ask(17'sd65050);
    ask(17'sd65535);
    put_key(3'd7, 17'sd65300, 16'sd100);
    ask(17'sd65400);
    // End marker in the first slot leaves the track empty.
    put_key(3'd0, -17'sd1, 16'sd1);
    ask(17'sd0);

    while (n_writes + n_queries < NUM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      sel  = $urandom_range(0, 99);
      if (sel < 70) begin
        // Ascending track, optionally closed by an end marker, then queries.
        case ($urandom_range(0, 2))
          0:       step = 4;
          1:       step = 200;
          default: step = 9000;
        endcase
        nkeys  = $urandom_range(0, 8);
        t      = $urandom_range(0, step);
        last_t = 0;
        for (int i = 0; i < nkeys; i++) begin
          if (i > 0 && $urandom_range(0, 9) != 0) t = t + $urandom_range(1, step);
          if (t > 65535) begin
            nkeys = i;
            break;
          end
          put_key(3'(i), 17'(t), ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, 1023) - 512));
          last_t = t;
        end
        if (nkeys < 8)
          put_key(3'(nkeys), ($urandom_range(0, 3) == 0) ? {1'b1, 16'($urandom)}
                                                        : -17'sd1, 16'($urandom));
        t_hi = (last_t + step > 65535) ? 65535 : last_t + step;
        nq   = $urandom_range(3, 10);
        for (int i = 0; i < nq; i++) begin
          sel = $urandom_range(0, 9);
          if (sel < 4 && nkeys > 0) ask(planned_time[$urandom_range(0, nkeys - 1)]);
          else if (sel < 8) ask(17'($urandom_range(0, t_hi)));
          else if (sel == 8) ask({1'b1, 16'($urandom)});
          else ask(17'($urandom));
        end
      end else if (sel < 85) begin
        // Scattered writes leave the key times out of order.
        repeat ($urandom_range(1, 5))
          put_key(3'($urandom), ($urandom_range(0, 9) == 0) ? {1'b1, 16'($urandom)}
                                : 17'($urandom_range(0, 65535)), 16'($urandom));
        repeat ($urandom_range(1, 4)) ask(17'($urandom_range(0, 65535)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_req(1'($urandom), 3'($urandom), 17'($urandom), 16'($urandom),
                   17'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d key writes and %0d track queries with random gaps and stalls.",
             n_writes, n_queries);
    $display("Checked %0d track values, %0d of them interpolated between keys.",
             results_seen, interpolated);
    if (errors == 0) begin
      $display("keyframe_linear_interpolator verification clean");
    end else begin
      $display("keyframe_linear_interpolator verification failed");
    end
    $finish;
  end

endmodule
